FILE: design/vrb_pkg.sv
// Package for the video chip register bank.
// Holds the window size, register addresses, command codes and reset values.
// No dependencies.
package vrb_pkg;

	// Register window size and address width
	localparam int VRB_WINDOW = 64;
	localparam int VRB_AW     = $clog2(VRB_WINDOW);
	localparam int VRB_DW     = 8;

	// Commands
	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_EVENT = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef logic [VRB_AW-1:0] reg_addr_t;

	// Register addresses with special behavior
	localparam reg_addr_t ADDR_CTRL1    = 6'h11;
	localparam reg_addr_t ADDR_RASTER   = 6'h12;
	localparam reg_addr_t ADDR_PEN_X    = 6'h13;
	localparam reg_addr_t ADDR_PEN_Y    = 6'h14;
	localparam reg_addr_t ADDR_CTRL2    = 6'h16;
	localparam reg_addr_t ADDR_Y_EXPAND = 6'h17;
	localparam reg_addr_t ADDR_MEM_PTR  = 6'h18;
	localparam reg_addr_t ADDR_IRQ_FLAG = 6'h19;
	localparam reg_addr_t ADDR_IRQ_MASK = 6'h1a;
	localparam reg_addr_t ADDR_COLL_SS  = 6'h1e;
	localparam reg_addr_t ADDR_COLL_SD  = 6'h1f;

	// Plain stored registers: sprite positions, enables, priority, expansion
	localparam reg_addr_t ADDR_SPR_POS      = 6'h00;
	localparam reg_addr_t ADDR_SPR_X_MSB    = 6'h10;
	localparam reg_addr_t ADDR_SPR_ENABLE   = 6'h15;
	localparam reg_addr_t ADDR_SPR_PRIO     = 6'h1b;
	localparam reg_addr_t ADDR_SPR_X_EXPAND = 6'h1d;

	// Color registers: low nibble stored, high nibble reads as ones
	localparam reg_addr_t ADDR_COLOR_FIRST = 6'h20;
	localparam reg_addr_t ADDR_COLOR_LAST  = 6'h2e;

	// Reset values of the control registers
	localparam logic [7:0] RST_CTRL1   = 8'h18;
	localparam logic [7:0] RST_CTRL2   = 8'h08;
	localparam logic [7:0] RST_MEM_PTR = 8'h15;

	// Display window lines
	localparam logic [5:0] TOP_LINE_25    = 6'd51;
	localparam logic [5:0] TOP_LINE_24    = 6'd55;
	localparam logic [7:0] BOTTOM_LINE_25 = 8'd251;
	localparam logic [7:0] BOTTOM_LINE_24 = 8'd247;

	// Reset value of one register byte
	function automatic logic [7:0] reset_byte(input reg_addr_t a);
		logic [7:0] v;
		begin
			case (a)
				ADDR_CTRL1:   v = RST_CTRL1;
				ADDR_CTRL2:   v = RST_CTRL2;
				ADDR_MEM_PTR: v = RST_MEM_PTR;
				default:      v = 8'h00;
			endcase
			return v;
		end
	endfunction

endpackage

FILE: design/vrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: design/video_chip_register_bank_core.sv
// Top level of the video chip register bank: register window, latches, decode.
// Depends on vrb_pkg and vrb_ram.
//
// Channel   Signals                                   Handshake
// command   cmd address write_data raster_line pen_*  start, taken when busy low
//           hit_sprite_sprite hit_sprite_data irq_causes
// result    read_data irq_request graphic_mode         done, one cycle strobe
//           text_mode top_line bottom_line *_base
//
// A transaction is taken every cycle (busy stays low); its result passes through the
// stage 1 registers and the result registers, with read data from the RAM's registered port.
// All state updates at the edge that takes the transaction.
// The receiver cannot stall: results stream out in order, one per transaction.
// Reset sets all control state to its reset values; RAM entries read as reset values until written.
module video_chip_register_bank_core
	import vrb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            cmd,
	input  logic [9:0]            address,
	input  logic [7:0]            write_data,
	input  logic [8:0]            raster_line,
	input  logic [7:0]            pen_x,
	input  logic [7:0]            pen_y,
	input  logic                  pen_active,
	input  logic [7:0]            hit_sprite_sprite,
	input  logic [7:0]            hit_sprite_data,
	input  logic [3:0]            irq_causes,
	output logic                  done,
	output logic [7:0]            read_data,
	output logic                  irq_request,
	output logic [2:0]            graphic_mode,
	output logic                  text_mode,
	output logic [5:0]            top_line,
	output logic [7:0]            bottom_line,
	output logic [13:0]           char_base,
	output logic [13:0]           screen_base,
	output logic [13:0]           bitmap_base
);

	logic      acc;
	cmd_t      op;
	reg_addr_t a;
	logic      is_wr;
	logic      is_rd;

	// Architectural state
	logic [VRB_WINDOW-1:0] valid_q;
	logic [7:0] ctrl1_q, ctrl2_q, mem_ptr_q, irq_mask_q;
	logic [7:0] coll_ss_q, coll_sd_q, expand_q;
	logic [3:0] irq_q;
	logic       ack_seen_q;

	logic [7:0] ctrl1_d, ctrl2_d, mem_ptr_d, irq_mask_d;
	logic [7:0] coll_ss_d, coll_sd_d, expand_d;
	logic [3:0] irq_d;
	logic       ack_seen_d;

	logic [7:0] live_byte;
	logic       from_mem;
	logic       nibble_reg;
	logic       irq_line_cur;

	// Stage 1 registers
	logic       vld_s1;
	logic       rd_s1;
	logic       from_mem_s1;
	logic       nibble_s1;
	logic       mem_valid_s1;
	logic [7:0] mem_rst_s1;
	logic [7:0] live_s1;
	logic       irq_req_s1;
	logic [7:0] ctrl1_s1, ctrl2_s1, mem_ptr_s1;
	logic [7:0] ram_rdata;
	logic [7:0] mem_byte;
	logic [7:0] rd_byte;

	// Result registers
	logic        done_q;
	logic [7:0]  read_data_q;
	logic        irq_request_q;
	logic [7:0]  ctrl1_r_q, ctrl2_r_q, mem_ptr_r_q;

	assign busy  = 1'b0;
	assign acc   = start && !busy;
	assign op    = cmd_t'(cmd);
	assign a     = address[VRB_AW-1:0];
	assign is_wr = acc && (op == CMD_WRITE);
	assign is_rd = acc && (op == CMD_READ);

	// Register byte store
	vrb_ram #(
		.WIDTH(VRB_DW),
		.DEPTH(VRB_WINDOW)
	) u_ram (
		.clk  (clk),
		.we   (is_wr),
		.waddr(a),
		.wdata(write_data),
		.raddr(a),
		.rdata(ram_rdata)
	);

	// Next state of control registers and latches
	always_comb begin
		ctrl1_d    = ctrl1_q;
		ctrl2_d    = ctrl2_q;
		mem_ptr_d  = mem_ptr_q;
		irq_mask_d = irq_mask_q;
		coll_ss_d  = coll_ss_q;
		coll_sd_d  = coll_sd_q;
		expand_d   = expand_q;
		irq_d      = irq_q;
		ack_seen_d = ack_seen_q;
		if (is_wr) begin
			case (a)
				ADDR_CTRL1:    ctrl1_d = write_data;
				ADDR_CTRL2:    ctrl2_d = write_data;
				ADDR_MEM_PTR:  mem_ptr_d = write_data;
				ADDR_IRQ_MASK: irq_mask_d = write_data;
				ADDR_Y_EXPAND: expand_d = expand_q | ~write_data;
				ADDR_IRQ_FLAG: begin
					if (write_data[3:0] != 4'h0) begin
						irq_d = 4'h0;
					end
					ack_seen_d = 1'b1;
				end
				default: ;
			endcase
		end else if (is_rd) begin
			case (a)
				ADDR_COLL_SS: coll_ss_d = 8'h00;
				ADDR_COLL_SD: coll_sd_d = 8'h00;
				default: ;
			endcase
		end else if (acc && (op == CMD_EVENT)) begin
			coll_ss_d = coll_ss_q | hit_sprite_sprite;
			coll_sd_d = coll_sd_q | hit_sprite_data;
			irq_d     = irq_q | irq_causes;
		end
	end

	// Read values that do not come from the RAM
	assign irq_line_cur = |(irq_q & irq_mask_q[3:0]);

	always_comb begin
		case (a)
			ADDR_CTRL1:    live_byte = {raster_line[8], ctrl1_q[6:0]};
			ADDR_RASTER:   live_byte = raster_line[7:0];
			ADDR_PEN_X:    live_byte = pen_active ? pen_x : 8'h00;
			ADDR_PEN_Y:    live_byte = pen_active ? pen_y : 8'h00;
			ADDR_CTRL2:    live_byte = {2'b11, ctrl2_q[5:0]};
			ADDR_IRQ_FLAG: live_byte = {irq_line_cur, 3'b111, irq_q};
			ADDR_IRQ_MASK: live_byte = {4'hf, irq_mask_q[3:0]};
			ADDR_COLL_SS:  live_byte = coll_ss_q;
			ADDR_COLL_SD:  live_byte = coll_sd_q;
			default:       live_byte = 8'hff;
		endcase
	end

	assign from_mem = (a inside {[ADDR_SPR_POS:ADDR_SPR_X_MSB], ADDR_SPR_ENABLE,
		ADDR_Y_EXPAND, ADDR_MEM_PTR, [ADDR_SPR_PRIO:ADDR_SPR_X_EXPAND],
		[ADDR_COLOR_FIRST:ADDR_COLOR_LAST]});
	assign nibble_reg = (a inside {[ADDR_COLOR_FIRST:ADDR_COLOR_LAST]});

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			ctrl1_q    <= RST_CTRL1;
			ctrl2_q    <= RST_CTRL2;
			mem_ptr_q  <= RST_MEM_PTR;
			irq_mask_q <= 8'h00;
			coll_ss_q  <= 8'h00;
			coll_sd_q  <= 8'h00;
			expand_q   <= 8'hff;
			irq_q      <= 4'h0;
			ack_seen_q <= 1'b0;
		end else begin
			if (is_wr) begin
				valid_q[a] <= 1'b1;
			end
			ctrl1_q    <= ctrl1_d;
			ctrl2_q    <= ctrl2_d;
			mem_ptr_q  <= mem_ptr_d;
			irq_mask_q <= irq_mask_d;
			coll_ss_q  <= coll_ss_d;
			coll_sd_q  <= coll_sd_d;
			expand_q   <= expand_d;
			irq_q      <= irq_d;
			ack_seen_q <= ack_seen_d;
		end
	end

	// Stage 1: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= acc;
		end
	end

	// Stage 1: payload, aligned with RAM read data
	always_ff @(posedge clk) begin
		rd_s1        <= is_rd;
		from_mem_s1  <= from_mem;
		nibble_s1    <= nibble_reg;
		mem_valid_s1 <= valid_q[a];
		mem_rst_s1   <= reset_byte(a);
		live_s1      <= live_byte;
		irq_req_s1   <= |(irq_d & irq_mask_d[3:0]);
		ctrl1_s1     <= ctrl1_d;
		ctrl2_s1     <= ctrl2_d;
		mem_ptr_s1   <= mem_ptr_d;
	end

	// Read data select
	assign mem_byte = mem_valid_s1 ? ram_rdata : mem_rst_s1;

	always_comb begin
		if (!rd_s1) begin
			rd_byte = 8'h00;
		end else if (!from_mem_s1) begin
			rd_byte = live_s1;
		end else if (nibble_s1) begin
			rd_byte = {4'hf, mem_byte[3:0]};
		end else begin
			rd_byte = mem_byte;
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		read_data_q   <= rd_byte;
		irq_request_q <= irq_req_s1;
		ctrl1_r_q     <= ctrl1_s1;
		ctrl2_r_q     <= ctrl2_s1;
		mem_ptr_r_q   <= mem_ptr_s1;
	end

	// Control field decode
	assign done         = done_q;
	assign read_data    = read_data_q;
	assign irq_request  = irq_request_q;
	assign graphic_mode = {ctrl1_r_q[6], ctrl1_r_q[5], ctrl2_r_q[4]};
	assign text_mode    = !ctrl1_r_q[5];
	assign top_line     = ctrl1_r_q[3] ? TOP_LINE_25 : TOP_LINE_24;
	assign bottom_line  = ctrl1_r_q[3] ? BOTTOM_LINE_25 : BOTTOM_LINE_24;
	assign char_base    = {mem_ptr_r_q[3:1], 11'd0};
	assign screen_base  = {mem_ptr_r_q[7:4], 10'd0};
	assign bitmap_base  = {mem_ptr_r_q[3], 13'd0};

endmodule
